@@ design/tda_pkg.sv @@
// Shared types and constants for the tuning dial accelerator.
// Depends on nothing; the top level imports it.
`default_nettype none

package tda_pkg;

	localparam int unsigned STEP_W  = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RAW_W   = 8;
	localparam int unsigned IDLE_W  = 3;
	localparam int unsigned CFG_IDX_W = 3;

	// Timer constants that do not follow the timer range.
	localparam int unsigned TIMER_FLOOR     = 30;
	localparam int unsigned TIMER_PULLBACK  = 30;
	localparam int unsigned TIMER_DECREMENT = 5;

	localparam logic [IDLE_W-1:0] IDLE_LIMIT = IDLE_W'(5);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_STEP   = 3'd0,
		REG_STEP_LEVEL1 = 3'd1,
		REG_STEP_LEVEL2 = 3'd2,
		REG_STEP_LEVEL3 = 3'd3,
		REG_STEP_LEVEL4 = 3'd4
	} cfg_reg_t;

	typedef logic [STEP_W-1:0] step_t;

endpackage

`default_nettype wire

@@ design/tuning_dial_accelerator.sv @@
// Tuning dial accelerator: one poll per beat, acceleration state and step bands.
// Depends on tda_pkg. The result beat appears in the cycle after its input beat, and a
// new beat is taken every cycle while the result register is empty or being drained.
// The single result register is the only thing that can hold off the input side.
// Reset: timer at its maximum, counters and last sample cleared, all steps at 1.
`default_nettype none

module tuning_dial_accelerator #(
	parameter int unsigned TIMER_MAX     = 1000,
	parameter int unsigned SAMPLE_PERIOD = 50
) (
	input  wire                                  clk,
	input  wire                                  arst_n,

	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  pulse_new,
	input  wire                                  turn_up,
	input  wire  [tda_pkg::RAW_W-1:0]            raw_count,
	input  wire  signed [tda_pkg::VALUE_W-1:0]   value_in,

	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [tda_pkg::VALUE_W-1:0]   value_out,
	output logic [tda_pkg::STEP_W-1:0]           step_applied,

	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [tda_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [tda_pkg::STEP_W-1:0]           cfg_data
);

	import tda_pkg::*;

	// The timer can sit up to TIMER_PULLBACK-1 above its maximum after an idle
	// pull-back, so it needs room for that overshoot.
	localparam int unsigned TW = $clog2(TIMER_MAX + TIMER_PULLBACK);
	// The poll counter must hold SAMPLE_PERIOD itself.
	localparam int unsigned PW = $clog2(SAMPLE_PERIOD + 1);

	localparam logic [TW-1:0] TMAX     = TW'(TIMER_MAX);
	localparam logic [TW-1:0] TFLOOR   = TW'(TIMER_FLOOR);
	localparam logic [TW-1:0] TPULL    = TW'(TIMER_PULLBACK);
	localparam logic [TW-1:0] TDEC     = TW'(TIMER_DECREMENT);
	localparam logic [TW-1:0] BAND80   = TW'((TIMER_MAX / 100) * 80);
	localparam logic [TW-1:0] BAND60   = TW'((TIMER_MAX / 100) * 60);
	localparam logic [TW-1:0] BAND40   = TW'((TIMER_MAX / 100) * 40);
	localparam logic [TW-1:0] BAND20   = TW'((TIMER_MAX / 100) * 20);
	localparam logic [PW-1:0] PERIOD   = PW'(SAMPLE_PERIOD);

	// Configuration registers.
	step_t base_step_q;
	step_t step_level1_q;
	step_t step_level2_q;
	step_t step_level3_q;
	step_t step_level4_q;

	// Acceleration state.
	logic [TW-1:0]     spin_timer_q;
	logic [PW-1:0]     poll_count_q;
	logic [IDLE_W-1:0] idle_checks_q;
	step_t             current_step_q;
	logic [RAW_W-1:0]  last_raw_q;

	// Next-state values for the beat being accepted.
	logic [TW-1:0]        timer_d;
	logic [PW-1:0]        poll_d;
	logic [IDLE_W-1:0]    idle_d;
	step_t                step_d;
	logic [RAW_W-1:0]     last_raw_d;
	logic [VALUE_W-1:0]   value_d;
	step_t                applied_d;

	logic in_fire;

	// The result register empties when taken, so the input side only waits when
	// a finished result is still sitting there and downstream is stalled.
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration writes. Indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q   <= STEP_W'(1);
			step_level1_q <= STEP_W'(1);
			step_level2_q <= STEP_W'(1);
			step_level3_q <= STEP_W'(1);
			step_level4_q <= STEP_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BASE_STEP:   base_step_q   <= cfg_data;
				REG_STEP_LEVEL1: step_level1_q <= cfg_data;
				REG_STEP_LEVEL2: step_level2_q <= cfg_data;
				REG_STEP_LEVEL3: step_level3_q <= cfg_data;
				REG_STEP_LEVEL4: step_level4_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// One poll. A pulse moves the value and speeds the timer down; an idle poll
	// that lands on the sample period pulls the timer back up and checks whether
	// the raw encoder counter has moved since the last check.
	always_comb begin
		logic [TW-1:0]     floored;
		logic [IDLE_W-1:0] idle_inc;

		floored    = (spin_timer_q < TFLOOR) ? TFLOOR : spin_timer_q;
		idle_inc   = (idle_checks_q < IDLE_LIMIT) ? idle_checks_q + IDLE_W'(1) : idle_checks_q;
		timer_d    = spin_timer_q;
		idle_d     = idle_checks_q;
		last_raw_d = last_raw_q;
		value_d    = value_in;
		applied_d  = '0;

		if (pulse_new) begin
			applied_d = current_step_q;
			if (turn_up) begin
				value_d = value_in + VALUE_W'(current_step_q);
			end else begin
				value_d = value_in - VALUE_W'(current_step_q);
			end
			idle_d  = '0;
			timer_d = ((floored >= TMAX) ? TMAX : floored) - TDEC;
		end else if (poll_count_q == PERIOD) begin
			timer_d = ((floored >= TMAX) ? (TMAX - TPULL) : floored) + TPULL;
			if (raw_count != last_raw_q) begin
				last_raw_d = raw_count;
			end else begin
				idle_d = idle_inc;
				// A dial that stayed still for enough checks starts over slow.
				if (idle_inc >= IDLE_LIMIT) begin
					timer_d = TMAX;
				end
			end
		end

		// The poll counter runs through SAMPLE_PERIOD and then wraps.
		poll_d = (poll_count_q >= PERIOD) ? '0 : poll_count_q + PW'(1);

		// The next step comes from the band the new timer value falls in.
		if (timer_d > BAND80) begin
			step_d = base_step_q;
		end else if (timer_d > BAND60) begin
			step_d = step_level1_q;
		end else if (timer_d > BAND40) begin
			step_d = step_level2_q;
		end else if (timer_d > BAND20) begin
			step_d = step_level3_q;
		end else begin
			step_d = step_level4_q;
		end
	end

	// State moves only on an accepted beat. The first step is 1, the reset value
	// of the base step, whatever is written before the first poll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_timer_q   <= TMAX;
			poll_count_q   <= '0;
			idle_checks_q  <= '0;
			current_step_q <= STEP_W'(1);
			last_raw_q     <= '0;
		end else if (in_fire) begin
			spin_timer_q   <= timer_d;
			poll_count_q   <= poll_d;
			idle_checks_q  <= idle_d;
			current_step_q <= step_d;
			last_raw_q     <= last_raw_d;
		end
	end

	// Result register: valid is control state, the payload loads on a beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_out    <= signed'(value_d);
			step_applied <= applied_d;
		end
	end

	// The idle pull-back can overshoot the maximum by less than one pull-back.
	a_timer_range: assert property (@(posedge clk) disable iff (!arst_n)
		spin_timer_q < TMAX + TPULL)
		else $error("spin timer beyond its overshoot range");

	a_idle_sat: assert property (@(posedge clk) disable iff (!arst_n)
		idle_checks_q <= IDLE_LIMIT)
		else $error("idle check count past its limit");

	a_poll_range: assert property (@(posedge clk) disable iff (!arst_n)
		poll_count_q <= PERIOD)
		else $error("poll counter past the sample period");

	// A poll without a pulse reports no step and leaves the value untouched.
	a_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !pulse_new |=>
			out_valid && step_applied == '0 && value_out == $past(value_in))
		else $error("idle poll changed the value or reported a step");

endmodule

`default_nettype wire

@@ tb/tb_tuning_dial_accelerator.sv @@
// Testbench for the tuning dial accelerator: drives polls and step register writes,
// predicts every result beat with its own copy of the dial state, and checks it.
// Depends on tda_pkg and tuning_dial_accelerator.
`timescale 1ns / 100ps

module tb_tuning_dial_accelerator;

	import tda_pkg::*;

	// The block is built with its default timer range and sampling period; the
	// predictor below uses the same numbers.
	localparam int unsigned TIMER_MAX     = 1000;
	localparam int unsigned SAMPLE_PERIOD = 50;

	// Dial behavior constants, kept here so that the predictor stands on its own.
	localparam int unsigned SPIN_FLOOR    = 30;
	localparam int unsigned SPIN_PULLBACK = 30;
	localparam int unsigned SPIN_DECAY    = 5;
	localparam int unsigned IDLE_SATURATE = 5;

	localparam int unsigned RESULT_LATENCY = 1;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned QUIET_LIMIT    = 3000;
	localparam int unsigned REPORT_LIMIT   = 10;

	typedef logic [VALUE_W-1:0] dial_value_t;

	// One result beat as the block should present it.
	typedef struct {
		dial_value_t value;
		step_t       step;
	} dial_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 pulse_new = 1'b0;
	logic                 turn_up   = 1'b0;
	logic [RAW_W-1:0]     raw_count = '0;
	dial_value_t          value_in  = '0;

	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [VALUE_W-1:0] value_out;
	step_t                step_applied;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	step_t                cfg_data  = '0;

	tuning_dial_accelerator #(
		.TIMER_MAX     (TIMER_MAX),
		.SAMPLE_PERIOD (SAMPLE_PERIOD)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pulse_new    (pulse_new),
		.turn_up      (turn_up),
		.raw_count    (raw_count),
		.value_in     (value_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value_out    (value_out),
		.step_applied (step_applied),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Dial predictor. It mirrors the acceleration state of the block: the
	// spin timer, the poll phase within one sampling period, the count of
	// idle checks that found the dial still, the last raw counter sample and
	// the step that the next pulse will apply. The step registers are
	// updated when a write beat is accepted.
	// ------------------------------------------------------------------
	step_t        band_steps [5] = '{default: 16'd1};
	int unsigned  spin_timer_model = TIMER_MAX;
	int unsigned  poll_phase       = 0;
	int unsigned  still_checks     = 0;
	logic [RAW_W-1:0] sampled_raw  = '0;
	step_t        armed_step       = 16'd1;

	dial_result_t pending_dial_results [$];

	// Bands are edges at 80, 60, 40 and 20 percent of the timer range. A low
	// timer means a fast spin and therefore a higher step level.
	function automatic step_t band_step(input int unsigned timer);
		int unsigned unit;
		unit = TIMER_MAX / 100;
		if (timer > unit * 80)
			return band_steps[REG_BASE_STEP];
		if (timer > unit * 60)
			return band_steps[REG_STEP_LEVEL1];
		if (timer > unit * 40)
			return band_steps[REG_STEP_LEVEL2];
		if (timer > unit * 20)
			return band_steps[REG_STEP_LEVEL3];
		return band_steps[REG_STEP_LEVEL4];
	endfunction

	// Advances the dial state by one accepted poll and queues its result.
	function automatic void advance_dial(input logic pulse, input logic up,
			input logic [RAW_W-1:0] raw, input dial_value_t value);
		dial_result_t res;
		res.value = value;
		res.step  = '0;
		if (pulse) begin
			// A pulse moves the value, clears the idle run and brings the timer down.
			res.step  = armed_step;
			res.value = up ? value + {16'b0, armed_step} : value - {16'b0, armed_step};
			still_checks = 0;
			if (spin_timer_model < SPIN_FLOOR)
				spin_timer_model = SPIN_FLOOR;
			if (spin_timer_model >= TIMER_MAX)
				spin_timer_model = TIMER_MAX;
			spin_timer_model -= SPIN_DECAY;
		end else if (poll_phase == SAMPLE_PERIOD) begin
			// Idle check: pull the timer back, then look whether the dial moved.
			if (spin_timer_model < SPIN_FLOOR)
				spin_timer_model = SPIN_FLOOR;
			if (spin_timer_model >= TIMER_MAX)
				spin_timer_model = TIMER_MAX - SPIN_PULLBACK;
			spin_timer_model += SPIN_PULLBACK;
			if (raw != sampled_raw) begin
				sampled_raw = raw;
			end else begin
				if (still_checks < IDLE_SATURATE)
					still_checks++;
				if (still_checks >= IDLE_SATURATE)
					spin_timer_model = TIMER_MAX;
			end
		end
		poll_phase++;
		if (poll_phase > SAMPLE_PERIOD)
			poll_phase = 0;
		armed_step = band_step(spin_timer_model);
		pending_dial_results.push_back(res);
	endfunction

	// Every accepted poll beat feeds the predictor. The payload read here is
	// the value held before the edge, which is the one the block takes.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			advance_dial(pulse_new, turn_up, raw_count, value_in);
	end

	// ------------------------------------------------------------------
	// Result checking. Each result beat is matched against the oldest
	// prediction; a beat with nothing waiting is also a fault.
	// ------------------------------------------------------------------
	int unsigned fault_count = 0;

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : result_check
		dial_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_dial_results.size() == 0) begin
				report_fault($sformatf("unexpected result value %h step %h",
					value_out, step_applied));
			end else begin
				want = pending_dial_results.pop_front();
				if (value_out !== want.value || step_applied !== want.step)
					report_fault($sformatf("value exp %h got %h, step exp %h got %h",
						want.value, value_out, want.step, step_applied));
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver. It stalls at random with the current percentage, and on
	// request holds off for a long stretch counted here, which lets the
	// block fill up and push back on the poll side.
	// ------------------------------------------------------------------
	int unsigned out_stall_pct = 0;
	logic        hold_trigger  = 1'b0;
	logic        hold_seen     = 1'b0;
	int unsigned hold_left     = 0;

	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
		end
	end

	// Watchdog: a run that stops moving beats for too long has hung.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------
	int unsigned      in_gap_pct = 0;
	logic [RAW_W-1:0] last_raw_sent = '0;

	// Sends one poll beat. It is entered just after a rising edge and returns
	// at the edge where the beat is taken; valid stays high so that a poll
	// sent straight after needs no second assignment in the same step.
	task automatic send_poll(input logic pulse, input logic up,
			input logic [RAW_W-1:0] raw, input dial_value_t value);
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		pulse_new <= pulse;
		turn_up   <= up;
		raw_count <= raw;
		value_in  <= value;
		last_raw_sent = raw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Writes one step register while the block is idle. Indexes past the
	// last register are sent too; the block must ignore them.
	task automatic write_step_reg(input logic [CFG_IDX_W-1:0] idx, input step_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= REG_STEP_LEVEL4)
			band_steps[idx] = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_steps(input step_t s0, input step_t s1, input step_t s2,
			input step_t s3, input step_t s4);
		write_step_reg(REG_BASE_STEP, s0);
		write_step_reg(REG_STEP_LEVEL1, s1);
		write_step_reg(REG_STEP_LEVEL2, s2);
		write_step_reg(REG_STEP_LEVEL3, s3);
		write_step_reg(REG_STEP_LEVEL4, s4);
	endtask

	// Drops valid and waits until every predicted result has come back, then
	// waits longer in case the block emits something it should not.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_dial_results.size() != 0);
		repeat (RESULT_LATENCY + 3)
			@(posedge clk);
	endtask

	// Mostly random values, with the wrap points of the signed and unsigned ranges mixed in.
	function automatic dial_value_t pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Both directions and the no-pulse poll at the edges of the value and raw
	// fields, first with the reset steps of one, then with every step at its
	// maximum. The first poll after the write still uses the old step.
	task automatic test_directed_extremes();
		in_gap_pct = 0;
		out_stall_pct <= 0;
		send_poll(1'b1, 1'b1, 8'h00, 32'h0000_0000);
		send_poll(1'b1, 1'b1, 8'hFF, 32'h7FFF_FFFF);
		send_poll(1'b1, 1'b0, 8'h00, 32'h8000_0000);
		send_poll(1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b0, 8'hA5, 32'h0000_0000);
		send_poll(1'b0, 1'b1, 8'hFF, 32'h7FFF_FFFF);
		send_poll(1'b0, 1'b0, 8'h00, 32'h8000_0000);
		send_poll(1'b0, 1'b1, 8'h5A, 32'h1234_5678);
		drain_results();
		program_steps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_poll(1'b1, 1'b1, 8'h00, 32'h7FFF_FFFF);
		send_poll(1'b1, 1'b1, 8'hFF, 32'h7FFF_FFFF);
		send_poll(1'b1, 1'b0, 8'h00, 32'h8000_0000);
		send_poll(1'b1, 1'b0, 8'hFF, 32'h0000_0000);
		send_poll(1'b1, 1'b1, 8'h00, 32'hFFFF_0001);
		send_poll(1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// A full spin cycle with distinct steps per band: a long burst walks the
	// timer through every band down to the floor, a long still stretch pulls
	// it back until the idle count saturates and resets it to the maximum,
	// and an idle check just below the maximum leaves it above the range
	// until the next pulse clamps it. The spare register indexes are
	// written with random data on the way in.
	task automatic test_spin_cycle();
		logic [RAW_W-1:0] still_raw;
		for (int k = int'(REG_STEP_LEVEL4) + 1; k < (1 << CFG_IDX_W); k++)
			write_step_reg(CFG_IDX_W'(k), STEP_W'($urandom));
		program_steps(16'h0011, 16'h0203, 16'h0405, 16'h0809, 16'hF00D);
		in_gap_pct = 29;
		out_stall_pct <= 29;
		repeat (210)
			send_poll(1'b1, 1'($urandom_range(0, 1)), RAW_W'($urandom), pick_value());
		still_raw = RAW_W'($urandom);
		repeat (330)
			send_poll(1'b0, 1'($urandom_range(0, 1)), still_raw, pick_value());
		send_poll(1'b1, 1'b1, still_raw, pick_value());
		repeat (SAMPLE_PERIOD + 1)
			send_poll(1'b0, 1'b0, ~last_raw_sent, pick_value());
		repeat (4)
			send_poll(1'b1, 1'($urandom_range(0, 1)), RAW_W'($urandom), pick_value());
		drain_results();
	endtask

	// The receiver holds off for a long stretch while polls keep coming, so
	// the result register fills and the poll side must stall.
	task automatic test_backpressure();
		in_gap_pct = 0;
		out_stall_pct <= 0;
		hold_trigger <= ~hold_trigger;
		repeat (40)
			send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				RAW_W'($urandom), pick_value());
		drain_results();
	endtask

	// Random runs shaped like real dial use: bursts of pulses mostly in one
	// direction, still stretches with a steady raw counter, stretches where
	// the counter moves without pulses, and the odd fully random poll.
	task automatic test_random_polls(input int unsigned gap_pct, input int unsigned stall_pct,
			input int unsigned item_total);
		int unsigned sent;
		int unsigned run_len;
		int unsigned kind;
		logic        dir;
		logic [RAW_W-1:0] still_raw;
		sent = 0;
		in_gap_pct = gap_pct;
		out_stall_pct <= stall_pct;
		while (sent < item_total) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				run_len = $urandom_range(1, 40);
				dir = 1'($urandom_range(0, 1));
				repeat (run_len)
					send_poll(1'b1, ($urandom_range(0, 7) == 0) ? !dir : dir,
						RAW_W'($urandom), pick_value());
			end else if (kind <= 6) begin
				run_len = $urandom_range(1, 120);
				still_raw = ($urandom_range(0, 3) == 0) ? RAW_W'($urandom) : last_raw_sent;
				repeat (run_len)
					send_poll(1'b0, 1'($urandom_range(0, 1)), still_raw, pick_value());
			end else if (kind <= 8) begin
				run_len = $urandom_range(1, 60);
				repeat (run_len)
					send_poll(1'b0, 1'($urandom_range(0, 1)), RAW_W'($urandom),
						pick_value());
			end else begin
				run_len = 1;
				send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					RAW_W'($urandom), $urandom);
			end
			sent += run_len;
		end
		drain_results();
	endtask

	// ------------------------------------------------------------------
	// Sequence: one reset at the start, then the tests in turn, with the
	// step registers reprogrammed between random phases.
	// ------------------------------------------------------------------
	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_spin_cycle();
		test_backpressure();

		program_steps(STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
			STEP_W'($urandom), STEP_W'($urandom));
		test_random_polls(0, 0, 100);
		program_steps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		test_random_polls(47, 0, 100);
		program_steps(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		test_random_polls(0, 47, 100);
		program_steps(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h0001);
		test_random_polls(29, 29, 100);

		if (fault_count == 0 && pending_dial_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
